@@ src/mbph_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter ballistics package
// Beat types, register indexes, sequencer codes and the step program ROM.
// ----------------------------------------------------------------------------
package mbph_pkg;

  localparam int NUM_LEVELS = 12;
  localparam int NUM_CNTS   = 3;

  typedef struct packed {
    logic signed [15:0] in_peak_db;
    logic signed [15:0] out_peak_db;
    logic signed [15:0] in_left_db;
    logic signed [15:0] in_right_db;
    logic signed [15:0] out_left_db;
    logic signed [15:0] out_right_db;
    logic signed [15:0] in_rms_db;
    logic signed [15:0] out_rms_db;
    logic signed [15:0] reduction_db;
  } mbph_in_t;

  typedef struct packed {
    logic signed [15:0] peak_in;
    logic signed [15:0] peak_out;
    logic signed [15:0] peak_in_left;
    logic signed [15:0] peak_in_right;
    logic signed [15:0] peak_out_left;
    logic signed [15:0] peak_out_right;
    logic signed [15:0] average_in;
    logic signed [15:0] average_out;
    logic signed [15:0] hold_in;
    logic signed [15:0] hold_out;
    logic signed [15:0] smoothed_reduction;
    logic signed [15:0] reduction_hold;
  } mbph_out_t;

  // configuration register indexes
  localparam logic [7:0] REG_PEAK_ATTACK  = 8'd0;
  localparam logic [7:0] REG_PEAK_RELEASE = 8'd1;
  localparam logic [7:0] REG_VU           = 8'd2;
  localparam logic [7:0] REG_GR_ATTACK    = 8'd3;
  localparam logic [7:0] REG_GR_RELEASE   = 8'd4;
  localparam logic [7:0] REG_PEAK_TICKS   = 8'd5;
  localparam logic [7:0] REG_GR_TICKS     = 8'd6;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_READ  = 3'b001,
    PH_MUL   = 3'b010,
    PH_WRITE = 3'b100
  } phase_t;

  // step operations
  localparam logic [1:0] OP_FOLLOW  = 2'd0;
  localparam logic [1:0] OP_AVG     = 2'd1;
  localparam logic [1:0] OP_HOLD_GE = 2'd2;
  localparam logic [1:0] OP_HOLD_GT = 2'd3;

  // coefficient sets
  localparam logic [1:0] CS_PEAK = 2'd0;
  localparam logic [1:0] CS_VU   = 2'd1;
  localparam logic [1:0] CS_GR   = 2'd2;

  // level register file slots
  localparam logic [3:0] LV_PEAK_IN        = 4'd0;
  localparam logic [3:0] LV_PEAK_OUT       = 4'd1;
  localparam logic [3:0] LV_PEAK_IN_LEFT   = 4'd2;
  localparam logic [3:0] LV_PEAK_IN_RIGHT  = 4'd3;
  localparam logic [3:0] LV_PEAK_OUT_LEFT  = 4'd4;
  localparam logic [3:0] LV_PEAK_OUT_RIGHT = 4'd5;
  localparam logic [3:0] LV_AVG_IN         = 4'd6;
  localparam logic [3:0] LV_AVG_OUT        = 4'd7;
  localparam logic [3:0] LV_HOLD_IN        = 4'd8;
  localparam logic [3:0] LV_HOLD_OUT       = 4'd9;
  localparam logic [3:0] LV_GR             = 4'd10;
  localparam logic [3:0] LV_GR_HOLD        = 4'd11;

  // input field selects
  localparam logic [3:0] SRC_IN_PEAK   = 4'd0;
  localparam logic [3:0] SRC_OUT_PEAK  = 4'd1;
  localparam logic [3:0] SRC_IN_LEFT   = 4'd2;
  localparam logic [3:0] SRC_IN_RIGHT  = 4'd3;
  localparam logic [3:0] SRC_OUT_LEFT  = 4'd4;
  localparam logic [3:0] SRC_OUT_RIGHT = 4'd5;
  localparam logic [3:0] SRC_IN_RMS    = 4'd6;
  localparam logic [3:0] SRC_OUT_RMS   = 4'd7;
  localparam logic [3:0] SRC_REDUCTION = 4'd8;

  // hold counters
  localparam logic [1:0] CNT_IN  = 2'd0;
  localparam logic [1:0] CNT_OUT = 2'd1;
  localparam logic [1:0] CNT_GR  = 2'd2;

  localparam logic [3:0] PC_LAST = 4'd11;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] lvl;
    logic       tgt_last;
    logic [3:0] src;
    logic [1:0] cset;
    logic [1:0] cnt;
    logic       last;
  } ucode_t;

  // holds take the level written by the step just before them as target
  function automatic ucode_t ucode_rom(input logic [3:0] pc);
    ucode_t w;
    case (pc)
      4'd0:  w = '{OP_FOLLOW,  LV_PEAK_IN,        1'b0, SRC_IN_PEAK,   CS_PEAK, CNT_IN,  1'b0};
      4'd1:  w = '{OP_HOLD_GE, LV_HOLD_IN,        1'b1, SRC_IN_PEAK,   CS_PEAK, CNT_IN,  1'b0};
      4'd2:  w = '{OP_FOLLOW,  LV_PEAK_OUT,       1'b0, SRC_OUT_PEAK,  CS_PEAK, CNT_OUT, 1'b0};
      4'd3:  w = '{OP_HOLD_GE, LV_HOLD_OUT,       1'b1, SRC_OUT_PEAK,  CS_PEAK, CNT_OUT, 1'b0};
      4'd4:  w = '{OP_FOLLOW,  LV_PEAK_IN_LEFT,   1'b0, SRC_IN_LEFT,   CS_PEAK, CNT_IN,  1'b0};
      4'd5:  w = '{OP_FOLLOW,  LV_PEAK_IN_RIGHT,  1'b0, SRC_IN_RIGHT,  CS_PEAK, CNT_IN,  1'b0};
      4'd6:  w = '{OP_FOLLOW,  LV_PEAK_OUT_LEFT,  1'b0, SRC_OUT_LEFT,  CS_PEAK, CNT_IN,  1'b0};
      4'd7:  w = '{OP_FOLLOW,  LV_PEAK_OUT_RIGHT, 1'b0, SRC_OUT_RIGHT, CS_PEAK, CNT_IN,  1'b0};
      4'd8:  w = '{OP_AVG,     LV_AVG_IN,         1'b0, SRC_IN_RMS,    CS_VU,   CNT_IN,  1'b0};
      4'd9:  w = '{OP_AVG,     LV_AVG_OUT,        1'b0, SRC_OUT_RMS,   CS_VU,   CNT_IN,  1'b0};
      4'd10: w = '{OP_FOLLOW,  LV_GR,             1'b0, SRC_REDUCTION, CS_GR,   CNT_GR,  1'b0};
      PC_LAST: w = '{OP_HOLD_GT, LV_GR_HOLD,      1'b1, SRC_REDUCTION, CS_GR,   CNT_GR,  1'b1};
      default: w = '{OP_AVG,   LV_AVG_IN,         1'b1, SRC_IN_PEAK,   CS_VU,   CNT_IN,  1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ src/meter_ballistics_peak_hold_top.sv @@
// ----------------------------------------------------------------------------
// Meter ballistics with peak hold
// Microcoded one-pole followers, VU averages and hold/decay for one tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one meter tick of nine levels per beat.
//   out_valid/out_ready/out_data carry the twelve smoothed levels per beat.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write coefficient and hold-tick
//   registers; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A tick runs a 12-step program on one shared multiply datapath. A filter
//   step passes through read/select, multiply and round/saturate/write; a
//   hold step that captures jumps past the multiply. One tick is in flight
//   at a time and the next input beat is taken the cycle after the result
//   is loaded into the output register.
// Reset:
//   rst restores register defaults, levels and holds to -60 dB (gain
//   reduction to zero) and clears the hold counters.
// Stall:
//   A finished result waits in the output register; a new tick may run while
//   it waits, and its result is held back until the register frees.
// ----------------------------------------------------------------------------
module meter_ballistics_peak_hold_top
  import mbph_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 8,
  parameter int COEFF_FRAC_BITS = 16,
  parameter int HOLD_COUNT_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mbph_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mbph_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int FLOOR_FULL = -60 * (1 << LEVEL_FRAC_BITS);
  localparam logic signed [15:0] FLOOR_DB =
    (FLOOR_FULL < -32768) ? 16'sh8000 : 16'(FLOOR_FULL);
  localparam logic signed [34:0] HALF = 35'sd1 <<< (COEFF_FRAC_BITS - 1);
  localparam logic [HOLD_COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [HOLD_COUNT_BITS-1:0] CNT_ONE  = HOLD_COUNT_BITS'(1);

  state_t state;
  phase_t phase;
  logic [3:0] upc;

  logic [15:0] peak_attack_coeff, peak_release_coeff, vu_coeff;
  logic [15:0] gr_attack_coeff, gr_release_coeff;
  logic [9:0]  peak_hold_ticks, gr_hold_ticks;

  logic signed [15:0] levels [NUM_LEVELS];
  logic [HOLD_COUNT_BITS-1:0] cnts [NUM_CNTS];

  mbph_in_t           in_q;
  mbph_out_t          out_q;
  logic signed [15:0] last_q;
  logic signed [15:0] val_q, tgt_q;
  logic signed [16:0] diff_q;
  logic [15:0]        coeff_q;
  logic               cap_q;
  logic signed [33:0] prod_q;

  ucode_t             uw;
  logic signed [15:0] val, src_val, tgt;
  logic [15:0]        att, rel, coeff;
  logic [9:0]         ticks;
  logic [HOLD_COUNT_BITS+9:0] ticks_ext;
  logic [HOLD_COUNT_BITS-1:0] cnt_cur, cnt_dec, cnt_next;
  logic               is_hold, capture;
  logic signed [16:0] diff, coeff_s;
  logic signed [33:0] prod;
  logic signed [34:0] rnd;
  logic signed [35:0] sum;
  logic signed [15:0] sat_sum, result;
  logic               out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_data  = out_q;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    uw  = ucode_rom(upc);
    val = levels[uw.lvl];
    case (uw.src)
      SRC_IN_PEAK:   src_val = in_q.in_peak_db;
      SRC_OUT_PEAK:  src_val = in_q.out_peak_db;
      SRC_IN_LEFT:   src_val = in_q.in_left_db;
      SRC_IN_RIGHT:  src_val = in_q.in_right_db;
      SRC_OUT_LEFT:  src_val = in_q.out_left_db;
      SRC_OUT_RIGHT: src_val = in_q.out_right_db;
      SRC_IN_RMS:    src_val = in_q.in_rms_db;
      SRC_OUT_RMS:   src_val = in_q.out_rms_db;
      SRC_REDUCTION: src_val = in_q.reduction_db;
      default:       src_val = in_q.in_peak_db;
    endcase
    tgt = uw.tgt_last ? last_q : src_val;

    case (uw.cset)
      CS_PEAK: begin
        att = peak_attack_coeff;
        rel = peak_release_coeff;
      end
      CS_VU: begin
        att = vu_coeff;
        rel = vu_coeff;
      end
      CS_GR: begin
        att = gr_attack_coeff;
        rel = gr_release_coeff;
      end
      default: begin
        att = vu_coeff;
        rel = vu_coeff;
      end
    endcase
    ticks     = (uw.cset == CS_GR) ? gr_hold_ticks : peak_hold_ticks;
    ticks_ext = {{HOLD_COUNT_BITS{1'b0}}, ticks};

    cnt_cur = cnts[uw.cnt];
    cnt_dec = (cnt_cur != CNT_ZERO) ? cnt_cur - CNT_ONE : cnt_cur;
    is_hold = (uw.op == OP_HOLD_GE) || (uw.op == OP_HOLD_GT);
    case (uw.op)
      OP_HOLD_GE: capture = (tgt >= val);
      OP_HOLD_GT: capture = (tgt > val);
      default:    capture = 1'b0;
    endcase
    cnt_next = capture ? ticks_ext[HOLD_COUNT_BITS-1:0] : cnt_dec;

    // hold decays only once its counter is zero; zero coefficient keeps it
    if (is_hold) begin
      coeff = (cnt_dec == CNT_ZERO) ? rel : 16'd0;
    end else begin
      coeff = (tgt > val) ? att : rel;
    end
    diff = 17'(tgt) - 17'(val);

    coeff_s = {1'b0, coeff_q};
    prod    = diff_q * coeff_s;
    rnd     = (35'(prod_q) + HALF) >>> COEFF_FRAC_BITS;
    sum     = 36'(val_q) + 36'(rnd);
    if (sum > 36'sd32767) begin
      sat_sum = 16'sh7fff;
    end else if (sum < -36'sd32768) begin
      sat_sum = 16'sh8000;
    end else begin
      sat_sum = sum[15:0];
    end
    result = cap_q ? tgt_q : sat_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      phase              <= PH_READ;
      upc                <= '0;
      out_valid          <= 1'b0;
      peak_attack_coeff  <= 16'd32768;
      peak_release_coeff <= 16'd6554;
      vu_coeff           <= 16'd6554;
      gr_attack_coeff    <= 16'd32768;
      gr_release_coeff   <= 16'd6554;
      peak_hold_ticks    <= 10'd60;
      gr_hold_ticks      <= 10'd60;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        levels[i] <= (i >= int'(LV_GR)) ? 16'sd0 : FLOOR_DB;
      end
      for (int i = 0; i < NUM_CNTS; i++) begin
        cnts[i] <= CNT_ZERO;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PEAK_ATTACK:  peak_attack_coeff  <= cfg_data;
          REG_PEAK_RELEASE: peak_release_coeff <= cfg_data;
          REG_VU:           vu_coeff           <= cfg_data;
          REG_GR_ATTACK:    gr_attack_coeff    <= cfg_data;
          REG_GR_RELEASE:   gr_release_coeff   <= cfg_data;
          REG_PEAK_TICKS:   peak_hold_ticks    <= cfg_data[9:0];
          REG_GR_TICKS:     gr_hold_ticks      <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            phase <= PH_READ;
            upc   <= '0;
          end
        end
        S_RUN: begin
          case (phase)
            PH_READ: begin
              if (is_hold) begin
                cnts[uw.cnt] <= cnt_next;
              end
              phase <= capture ? PH_WRITE : PH_MUL;
            end
            PH_MUL: begin
              phase <= PH_WRITE;
            end
            PH_WRITE: begin
              levels[uw.lvl] <= result;
              phase          <= PH_READ;
              upc            <= upc + 4'd1;
              if (uw.last) begin
                state <= S_DONE;
              end
            end
            default: phase <= PH_READ;
          endcase
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (state == S_RUN && phase == PH_READ) begin
      val_q   <= val;
      tgt_q   <= tgt;
      diff_q  <= diff;
      coeff_q <= coeff;
      cap_q   <= capture;
    end
    if (state == S_RUN && phase == PH_MUL) begin
      prod_q <= prod;
    end
    if (state == S_RUN && phase == PH_WRITE) begin
      last_q <= result;
    end
    if (out_load) begin
      out_q <= '{levels[LV_PEAK_IN], levels[LV_PEAK_OUT], levels[LV_PEAK_IN_LEFT],
                 levels[LV_PEAK_IN_RIGHT], levels[LV_PEAK_OUT_LEFT],
                 levels[LV_PEAK_OUT_RIGHT], levels[LV_AVG_IN], levels[LV_AVG_OUT],
                 levels[LV_HOLD_IN], levels[LV_HOLD_OUT], levels[LV_GR],
                 levels[LV_GR_HOLD]};
    end
  end

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && ($past(state) == S_RUN) |-> $past(uw.last && phase == PH_WRITE))
    else $error("tick finished before the last program step");

  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> (phase == PH_READ))
    else $error("datapath phase active outside a running tick");

  a_capture_skips_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (phase == PH_MUL) |-> !cap_q)
    else $error("captured hold entered the multiply phase");
`endif

endmodule
